// File: rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 sequence decoder.
`default_nettype none

package u8d_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 31;
  localparam int LEN_W      = 3;
  localparam int LEAD_PAY_W = 7;
  localparam int CONT_PAY_W = 6;
  localparam int NUM_CONT   = 5;

  // Continuation bytes are 10xxxxxx.
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Sequence lengths; zero flags a malformed sequence.
  localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_5   = 3'd5;
  localparam logic [LEN_W-1:0] LEN_6   = 3'd6;

  typedef struct packed {
    logic [LEN_W-1:0]      len;
    logic [LEAD_PAY_W-1:0] payload;
  } lead_info_t;

  typedef struct packed {
    logic                  ok;
    logic [CONT_PAY_W-1:0] payload;
  } cont_info_t;

endpackage

`default_nettype wire

// File: rtl/u8d_lead.sv
// Lead lane: length and masked payload of the lead byte.
`default_nettype none

module u8d_lead
  import u8d_pkg::*;
(
  input  logic [BYTE_W-1:0] lead_byte,
  output lead_info_t        info
);

  always_comb begin
    info.len     = LEN_BAD;
    info.payload = '0;
    if (!lead_byte[7]) begin
      info.len     = LEN_1;
      info.payload = lead_byte[6:0];
    end else if (lead_byte[7:5] == 3'b110) begin
      info.len     = LEN_2;
      info.payload = {2'b0, lead_byte[4:0]};
    end else if (lead_byte[7:4] == 4'b1110) begin
      info.len     = LEN_3;
      info.payload = {3'b0, lead_byte[3:0]};
    end else if (lead_byte[7:3] == 5'b11110) begin
      info.len     = LEN_4;
      info.payload = {4'b0, lead_byte[2:0]};
    end else if (lead_byte[7:2] == 6'b111110) begin
      info.len     = LEN_5;
      info.payload = {5'b0, lead_byte[1:0]};
    end else if (lead_byte[7:1] == 7'b1111110) begin
      info.len     = LEN_6;
      info.payload = {6'b0, lead_byte[0]};
    end
    // lone continuation bytes and 0xFE/0xFF stay malformed
  end

endmodule

`default_nettype wire

// File: rtl/u8d_cont.sv
// Continuation lane: tag check and six-bit payload of one trailing byte.
`default_nettype none

module u8d_cont
  import u8d_pkg::*;
(
  input  logic [BYTE_W-1:0] cont_byte,
  output cont_info_t        info
);

  assign info.ok      = (cont_byte[7:6] == CONT_TAG);
  assign info.payload = cont_byte[CONT_PAY_W-1:0];

endmodule

`default_nettype wire

// File: rtl/u8d_merge.sv
// Merge stage: check the needed lanes and assemble the code point.
`default_nettype none

module u8d_merge
  import u8d_pkg::*;
(
  input  lead_info_t            lead,
  input  cont_info_t            conts [NUM_CONT],
  output logic [CP_W-1:0]       code_point,
  output logic [LEN_W-1:0]      used_bytes
);

  logic [NUM_CONT-1:0] need;
  logic [NUM_CONT-1:0] good;
  logic [CP_W-1:0]     cp_raw;
  logic                chain_ok;

  always_comb begin
    for (int i = 0; i < NUM_CONT; i++) begin
      good[i] = conts[i].ok;
    end
  end

  always_comb begin
    need   = '0;
    cp_raw = '0;
    case (lead.len)
      LEN_1: begin
        cp_raw = {24'b0, lead.payload};
      end
      LEN_2: begin
        need   = 5'b00001;
        cp_raw = {20'b0, lead.payload[4:0], conts[0].payload};
      end
      LEN_3: begin
        need   = 5'b00011;
        cp_raw = {15'b0, lead.payload[3:0], conts[0].payload, conts[1].payload};
      end
      LEN_4: begin
        need   = 5'b00111;
        cp_raw = {10'b0, lead.payload[2:0], conts[0].payload, conts[1].payload,
                  conts[2].payload};
      end
      LEN_5: begin
        need   = 5'b01111;
        cp_raw = {5'b0, lead.payload[1:0], conts[0].payload, conts[1].payload,
                  conts[2].payload, conts[3].payload};
      end
      LEN_6: begin
        need   = 5'b11111;
        cp_raw = {lead.payload[0], conts[0].payload, conts[1].payload,
                  conts[2].payload, conts[3].payload, conts[4].payload};
      end
      default: begin
        need   = '0;
        cp_raw = '0;
      end
    endcase
  end

  // every lane the lead byte asks for must carry a continuation tag
  assign chain_ok   = ((need & ~good) == '0) && (lead.len != LEN_BAD);
  assign code_point = chain_ok ? cp_raw : '0;
  assign used_bytes = chain_ok ? lead.len : LEN_BAD;

endmodule

`default_nettype wire

// File: rtl/utf8_sequence_decoder_top.sv
// Top level of the UTF-8 sequence decoder: lanes, pipeline registers, merge.
`default_nettype none

// Decodes one UTF-8 sequence from a six-byte window per beat. A window whose
// lead byte is ASCII returns that byte with length 1; a lead byte with k
// leading ones (k = 2..6) expects k-1 bytes of the form 10xxxxxx after it and
// returns the assembled code point with length k. A lone continuation byte,
// a lead of 0xFE or 0xFF, or a broken chain returns length 0 and code point
// 0; bytes beyond the sequence length are ignored. One beat is accepted
// every cycle while item_stall is low and is registered in stage one and
// then the output register. Stage one runs six lanes side by side (one lead
// lane, five continuation lanes) and registers what each lane found; stage
// two merges the lanes into the code point and length and holds it in the
// output register. Each stage advances whenever the stage after it is empty
// or moving, so stalls on the result side back up into item_stall.
module utf8_sequence_decoder_top
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [BYTE_W-1:0] byte0,
  input  logic [BYTE_W-1:0] byte1,
  input  logic [BYTE_W-1:0] byte2,
  input  logic [BYTE_W-1:0] byte3,
  input  logic [BYTE_W-1:0] byte4,
  input  logic [BYTE_W-1:0] byte5,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CP_W-1:0]   code_point,
  output logic [LEN_W-1:0]  used_bytes
);

  // Lane outputs, unregistered.
  lead_info_t lead_lane;
  cont_info_t cont_lane [NUM_CONT];
  logic [BYTE_W-1:0] cont_bytes [NUM_CONT];

  // Stage one registers.
  logic       s1_valid;
  lead_info_t s1_lead;
  cont_info_t s1_cont [NUM_CONT];

  // Merge outputs and handshake.
  logic [CP_W-1:0]  merge_cp;
  logic [LEN_W-1:0] merge_len;
  logic             s2_ready;
  logic             s1_ready;

  assign cont_bytes[0] = byte1;
  assign cont_bytes[1] = byte2;
  assign cont_bytes[2] = byte3;
  assign cont_bytes[3] = byte4;
  assign cont_bytes[4] = byte5;

  u8d_lead u_lead (
    .lead_byte (byte0),
    .info      (lead_lane)
  );

  for (genvar g = 0; g < NUM_CONT; g++) begin : g_cont
    u8d_cont u_cont (
      .cont_byte (cont_bytes[g]),
      .info      (cont_lane[g])
    );
  end

  // Output register frees up when empty or being drained this cycle.
  assign s2_ready   = !result_valid || !result_stall;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_stall = !s1_ready;

  // Stage one: capture lane findings on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_lead <= lead_lane;
      for (int i = 0; i < NUM_CONT; i++) begin
        s1_cont[i] <= cont_lane[i];
      end
    end
  end

  u8d_merge u_merge (
    .lead       (s1_lead),
    .conts      (s1_cont),
    .code_point (merge_cp),
    .used_bytes (merge_len)
  );

  // Stage two: hold the merged result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      code_point <= merge_cp;
      used_bytes <= merge_len;
    end
  end

  // A malformed sequence never carries a code point.
  a_bad_zero_cp: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (used_bytes == LEN_BAD)) |-> (code_point == '0))
    else $error("malformed result with nonzero code point");

  // Length never exceeds six bytes.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (used_bytes != 3'd7))
    else $error("used_bytes out of range");

  // A beat parked in stage one stays there while the output is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_lead)))
    else $error("stage one lost a beat under backpressure");

  // An ASCII lead always decodes with length one and a code point below 128.
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_ready && (s1_lead.len == LEN_1))
      |=> (used_bytes == LEN_1 && code_point[CP_W-1:LEAD_PAY_W] == '0))
    else $error("ASCII lead decoded wrongly");

endmodule

`default_nettype wire
